### sv/io_transaction_latency_tracker_assert.svh
// Assertion macros used by the checker of this block.
`ifndef IO_TRANSACTION_LATENCY_TRACKER_ASSERT_SVH
`define IO_TRANSACTION_LATENCY_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ILT_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilt check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ILT_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilt check failed");

`endif

### sv/ilt_pkg.sv
`timescale 1ns / 1ps

package ilt_pkg;

    localparam int S_TDATA_W = 176;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 304;
    localparam int M_TUSER_W = 1;

    localparam logic signed [10:0] CPU_KEEP = 11'sh7FF;

    typedef enum logic [1:0] {
        DIR_IN   = 2'd0,
        DIR_OUT  = 2'd1,
        DIR_SHUT = 2'd2,
        DIR_NONE = 2'd3
    } dir_t;

    typedef struct packed {
        logic              kind;
        logic              connection_present;
        dir_t              direction;
        logic [63:0]       enter_time;
        logic [63:0]       exit_time;
        logic signed [10:0] cpu;
        logic [31:0]       length;
    } event_t;

    typedef struct packed {
        logic              done_res;
        logic [63:0]       latency;
        logic [63:0]       request_start;
        logic [63:0]       response_end;
        logic signed [10:0] cpu_used;
        logic [31:0]       completed_count;
    } res_t;

endpackage

### sv/ilt_core.sv
`timescale 1ns / 1ps

module ilt_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          ev_valid,
    input  ilt_pkg::event_t ev,
    output ilt_pkg::res_t res
);

    logic               side_reg;
    ilt_pkg::dir_t      cur_dir_reg, cur_dir_next;
    logic [63:0]        cur_start_reg, cur_start_next;
    logic [63:0]        cur_end_reg, cur_end_next;
    logic [63:0]        cur_txn_start_reg, cur_txn_start_next;
    logic               older_pending_reg, older_pending_next;
    logic [63:0]        older_txn_start_reg, older_txn_start_next;
    logic [31:0]        in_bytes_reg, in_bytes_next;
    logic [31:0]        out_bytes_reg, out_bytes_next;
    logic signed [10:0] cpu_reg, cpu_next;
    logic [31:0]        count_reg, count_next;

    logic               switched;
    logic               done;
    logic               in_dir;
    logic [31:0]        bytes_sel;
    logic [31:0]        bytes_new;
    ilt_pkg::dir_t      req_dir;
    ilt_pkg::dir_t      rsp_dir;

    always_comb
    begin
        cur_dir_next         = cur_dir_reg;
        cur_start_next       = cur_start_reg;
        cur_end_next         = cur_end_reg;
        cur_txn_start_next   = cur_txn_start_reg;
        older_pending_next   = older_pending_reg;
        older_txn_start_next = older_txn_start_reg;
        in_bytes_next        = in_bytes_reg;
        out_bytes_next       = out_bytes_reg;
        cpu_next             = cpu_reg;
        count_next           = count_reg;
        switched             = 1'b0;
        done                 = 1'b0;
        in_dir               = (ev.direction == ilt_pkg::DIR_IN);
        bytes_sel            = in_dir ? in_bytes_reg : out_bytes_reg;
        bytes_new            = bytes_sel;
        req_dir              = side_reg ? ilt_pkg::DIR_IN : ilt_pkg::DIR_OUT;
        rsp_dir              = side_reg ? ilt_pkg::DIR_OUT : ilt_pkg::DIR_IN;

        if (ev_valid)
        begin
            if (ev.kind)
            begin
                in_bytes_next  = '0;
                out_bytes_next = '0;
            end
            else if (ev.connection_present)
            begin
                if (ev.cpu != ilt_pkg::CPU_KEEP)
                begin
                    cpu_next = ev.cpu;
                end
                case (ev.direction)
                    ilt_pkg::DIR_IN, ilt_pkg::DIR_OUT:
                    begin
                        bytes_new = bytes_sel + ev.length;
                        if (cur_dir_reg == ev.direction)
                        begin
                            cur_end_next = ev.exit_time;
                        end
                        else
                        begin
                            if (cur_dir_reg != ilt_pkg::DIR_NONE)
                            begin
                                switched  = 1'b1;
                                bytes_new = ev.length;
                            end
                            cur_start_next = ev.enter_time;
                            cur_end_next   = ev.exit_time;
                            if (ev.length != 32'd0)
                            begin
                                cur_dir_next = ev.direction;
                                // count equals this beat's length: fresh phase
                                if (switched || bytes_sel == 32'd0)
                                begin
                                    cur_txn_start_next = ev.exit_time;
                                end
                            end
                            else
                            begin
                                cur_dir_next = ilt_pkg::DIR_NONE;
                            end
                        end
                        if (in_dir)
                        begin
                            in_bytes_next = bytes_new;
                        end
                        else
                        begin
                            out_bytes_next = bytes_new;
                        end
                    end
                    ilt_pkg::DIR_SHUT:
                    begin
                        switched     = 1'b1;
                        cur_dir_next = ilt_pkg::DIR_NONE;
                    end
                    default:
                    begin
                    end
                endcase

                // the phase being closed is the one held before this beat
                if (switched)
                begin
                    if (cur_dir_reg == req_dir)
                    begin
                        older_pending_next   = (cur_start_reg != 64'd0);
                        older_txn_start_next = cur_txn_start_reg;
                    end
                    else if ((cur_dir_reg == rsp_dir || cur_dir_reg == ilt_pkg::DIR_SHUT)
                             && older_pending_reg)
                    begin
                        done               = 1'b1;
                        older_pending_next = 1'b0;
                        count_next         = count_reg + 32'd1;
                    end
                end
            end
        end

        res.done_res        = done;
        res.latency         = done ? (cur_end_reg - older_txn_start_reg) : 64'd0;
        res.request_start   = done ? older_txn_start_reg : 64'd0;
        res.response_end    = done ? cur_end_reg : 64'd0;
        res.cpu_used        = cpu_next;
        res.completed_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg            <= 1'b0;
            cur_dir_reg         <= ilt_pkg::DIR_NONE;
            cur_start_reg       <= '0;
            cur_end_reg         <= '0;
            cur_txn_start_reg   <= '0;
            older_pending_reg   <= 1'b0;
            older_txn_start_reg <= '0;
            in_bytes_reg        <= '0;
            out_bytes_reg       <= '0;
            cpu_reg             <= ilt_pkg::CPU_KEEP;
            count_reg           <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                side_reg <= cfg_wr_data;
            end
            cur_dir_reg         <= cur_dir_next;
            cur_start_reg       <= cur_start_next;
            cur_end_reg         <= cur_end_next;
            cur_txn_start_reg   <= cur_txn_start_next;
            older_pending_reg   <= older_pending_next;
            older_txn_start_reg <= older_txn_start_next;
            in_bytes_reg        <= in_bytes_next;
            out_bytes_reg       <= out_bytes_next;
            cpu_reg             <= cpu_next;
            count_reg           <= count_next;
        end
    end

endmodule

### sv/io_transaction_latency_tracker.sv
`timescale 1ns / 1ps

// Latency tracker for one I/O connection.
// s_axis: one event per beat. tuser = {connection_present, kind}; tdata holds
//   direction, enter_time, exit_time, cpu, length (lowest bits first).
// m_axis: exactly one result beat per event, in order. tuser = done_res;
//   tdata holds latency, request_start, response_end, cpu_used,
//   completed_count, total_latency.
// cfg_wr_en / cfg_wr_data write the side bit (0 client, 1 server); write it
//   only while no events are in flight.
// A result is registered in s1, then in the output stage; throughput is
//   one event per cycle while m_axis is ready. Connection state is updated
//   in the accept cycle, the running latency total in the output stage.
// Reset clears all phase state and counters, side becomes client and the
//   stored CPU becomes -1; both valid flags drop.
// A stalled m_axis holds its beat; the two stages keep filling, so s_axis
//   tready falls only once both hold a beat.
module io_transaction_latency_tracker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // direction, enter_time, exit_time, cpu, length, zero pad
    input  logic [ilt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind, connection_present
    input  logic [ilt_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // latency, request_start, response_end, cpu_used, completed_count,
    // total_latency, zero pad
    output logic [ilt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // done_res
    output logic [ilt_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    ilt_pkg::event_t ev;
    ilt_pkg::res_t   res;
    logic            accept;
    logic            out_ready;

    logic            s1_valid_reg;
    ilt_pkg::res_t   s1_res_reg;
    logic            m_valid_reg;
    ilt_pkg::res_t   m_res_reg;
    logic [63:0]     total_reg, total_next;

    assign ev.kind               = s_axis_tuser[0];
    assign ev.connection_present = s_axis_tuser[1];
    assign ev.direction          = ilt_pkg::dir_t'(s_axis_tdata[1:0]);
    assign ev.enter_time         = s_axis_tdata[65:2];
    assign ev.exit_time          = s_axis_tdata[129:66];
    assign ev.cpu                = s_axis_tdata[140:130];
    assign ev.length             = s_axis_tdata[172:141];

    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign total_next    = total_reg + s1_res_reg.latency;

    ilt_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ev_valid    (accept),
        .ev          (ev),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (out_ready)
            begin
                m_valid_reg <= s1_valid_reg;
            end
            if (s1_valid_reg && out_ready)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
        if (s1_valid_reg && out_ready)
        begin
            m_res_reg <= s1_res_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.done_res;
    assign m_axis_tdata  = {5'd0, total_reg, m_res_reg.completed_count, m_res_reg.cpu_used,
                            m_res_reg.response_end, m_res_reg.request_start,
                            m_res_reg.latency};

endmodule

### sv/ilt_checker.sv
`timescale 1ns / 1ps

`include "io_transaction_latency_tracker_assert.svh"

module ilt_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ilt_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [ilt_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    // held beat stays put
    `ILT_CHECK_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // input side only backs up when a result is waiting
    `ILT_CHECK(a_no_idle_stall, !s_axis_tready, m_axis_tvalid)

    // no completion: latency, request_start, response_end are zero
    `ILT_CHECK(a_zero_fields, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[191:0] == 192'd0)

    // completion: latency is response end minus request start
    `ILT_CHECK(a_latency, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[63:0] == (m_axis_tdata[191:128] - m_axis_tdata[127:64]))

endmodule

bind io_transaction_latency_tracker ilt_checker u_ilt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
